[hw/rtl/nfba_pkg.sv]
// Package: shared types, defaults and status codes of the next-fit block allocator.
package nfba_pkg;

   localparam int NUM_SLOTS_DEF   = 64;
   localparam int BLOCK_BYTES_DEF = 4;

   typedef logic [2:0] status_type;
   typedef logic [5:0] slot_out_type;
   typedef logic [8:0] offset_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_TOO_LARGE    = 3'd1;
   localparam status_type ST_POOL_FULL    = 3'd2;
   localparam status_type ST_NULL         = 3'd3;
   localparam status_type ST_FOREIGN      = 3'd4;
   localparam status_type ST_ALREADY_FREE = 3'd5;

   typedef struct packed {
      logic        cmd;
      logic [15:0] request_size;
      logic        handle_valid;
      logic [7:0]  free_slot;
   } req_type;

   typedef struct packed {
      status_type   status;
      slot_out_type given_slot;
      offset_type   data_offset;
   } rsp_type;

   // Status of the sequencer toward the channel logic.
   typedef struct packed {
      logic busy;
      logic done;
   } ctrl_stat_type;

endpackage

[hw/rtl/nfba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nfba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/nfba_ctrl.sv]
// Sequencer: clearing pass, next-fit slot scan and free check over the used-flag RAM.
module nfba_ctrl #(
   parameter int NUM_SLOTS   = nfba_pkg::NUM_SLOTS_DEF,
   parameter int BLOCK_BYTES = nfba_pkg::BLOCK_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  nfba_pkg::req_type      req_data,
   input  logic                   res_take,
   output nfba_pkg::ctrl_stat_type stat,
   output nfba_pkg::rsp_type      res_data
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam nfba_pkg::offset_type STRIDE = nfba_pkg::offset_type'(BLOCK_BYTES + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   nfba_pkg::rsp_type res_ff, res_in;

   logic [SLOT_W-1:0] pos_inc;
   logic [SLOT_W-1:0] free_idx;
   logic              too_large;
   logic              foreign;
   nfba_pkg::offset_type pos9;
   nfba_pkg::offset_type off_prod;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic              ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   logic              ram_rdata;

   assign pos_inc   = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign free_idx  = SLOT_W'(req_data.free_slot);
   assign too_large = req_data.request_size > 16'(BLOCK_BYTES);
   assign foreign   = 32'(req_data.free_slot) >= 32'(NUM_SLOTS);
   assign pos9      = nfba_pkg::offset_type'(pos_ff);
   assign off_prod  = pos9 * STRIDE;

   nfba_ram #(
      .WIDTH (1),
      .DEPTH (NUM_SLOTS)
   ) u_used (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = 1'b0;
      ram_raddr = pos_inc;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ram_raddr = (req_data.cmd == nfba_pkg::CMD_ALLOC) ? ptr_ff : free_idx;
            res_in    = '0;
            if (req_fire) begin
               if (req_data.cmd == nfba_pkg::CMD_ALLOC) begin
                  if (too_large) begin
                     res_in.status = nfba_pkg::ST_TOO_LARGE;
                     state_in      = S_DONE;
                  end else begin
                     pos_in   = ptr_ff;
                     cnt_in   = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (!req_data.handle_valid) begin
                     res_in.status = nfba_pkg::ST_NULL;
                     state_in      = S_DONE;
                  end else if (foreign) begin
                     res_in.status = nfba_pkg::ST_FOREIGN;
                     state_in      = S_DONE;
                  end else begin
                     pos_in   = free_idx;
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (!ram_rdata) begin
               ram_we                = 1'b1;
               ram_wdata             = 1'b1;
               ptr_in                = pos_inc;
               res_in.status         = nfba_pkg::ST_OK;
               res_in.given_slot     = nfba_pkg::slot_out_type'(pos_ff);
               res_in.data_offset    = off_prod + 9'd1;
               state_in              = S_DONE;
            end else if (cnt_ff == LAST_SLOT) begin
               res_in.status = nfba_pkg::ST_POOL_FULL;
               state_in      = S_DONE;
            end else begin
               pos_in = pos_inc;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FREE: begin
            if (ram_rdata) begin
               ram_we        = 1'b1;
               res_in.status = nfba_pkg::ST_OK;
            end else begin
               res_in.status = nfba_pkg::ST_ALREADY_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff <= pos_in;
      res_ff <= res_in;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = (state_ff == S_DONE);
   assign res_data  = res_ff;

`ifndef SYNTHESIS
   a_we_in_work_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_SCAN || state_ff == S_FREE))
      else $error("used-flag write outside clear, scan or free");

   a_ptr_moves_on_hit: assert property (@(posedge clock) disable iff (reset)
      (ptr_ff != $past(ptr_ff)) |-> ($past(reset) || $past(state_ff == S_SCAN && !ram_rdata)))
      else $error("search pointer moved without a scan hit");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status != nfba_pkg::ST_OK) |->
      (res_ff.given_slot == '0 && res_ff.data_offset == '0))
      else $error("refused request carries a slot or offset");

   a_clear_only_after_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && $past(state_ff != S_CLEAR)) |-> $past(reset))
      else $error("clearing pass re-entered without reset");
`endif

endmodule

[hw/rtl/next_fit_block_allocator_core.sv]
// Top level: next-fit fixed-block allocator with request and response channels.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------
//   req_    | in  | req_valid / req_stall | nfba_pkg::req_type
//   rsp_    | out | rsp_valid / rsp_stall | nfba_pkg::rsp_type
//
// Flow: one request at a time. An allocate scans the used-flag RAM from the search
// pointer onward, wrapping, one slot per cycle through its single read port, until it
// finds a free slot or has seen all NUM_SLOTS slots (pool full). A free reads the one
// flag that it names; a refused request goes straight to its result.
// Reset: a clearing pass writes every used flag to zero;
// req_stall stays high during it.
// Stalls: the response register holds a finished result while rsp_stall is high;
// the core still accepts and works on one more request, then holds that result
// in the sequencer, with req_stall high, until the register drains.
module next_fit_block_allocator_core #(
   parameter int NUM_SLOTS   = nfba_pkg::NUM_SLOTS_DEF,
   parameter int BLOCK_BYTES = nfba_pkg::BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nfba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nfba_pkg::rsp_type rsp_data
);

   nfba_pkg::ctrl_stat_type stat;
   nfba_pkg::rsp_type       res_data;
   logic                    req_fire;
   logic                    res_take;

   logic              rsp_valid_ff, rsp_valid_in;
   nfba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Accept only while the sequencer sits idle.
   assign req_stall = stat.busy;
   assign req_fire  = req_valid && !req_stall;

   // Output register is free when empty or being drained this cycle.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   nfba_ctrl #(
      .NUM_SLOTS   (NUM_SLOTS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .res_take (res_take),
      .stat     (stat),
      .res_data (res_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      // Load a finished result; otherwise hold or drop the drained one.
      if (stat.done && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      $past(stat.done && res_take) |-> (rsp_valid_ff && rsp_data_ff == $past(res_data)))
      else $error("finished result did not reach the response register");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> !req_fire)
      else $error("request accepted while a result is pending");

   a_stalled_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff && rsp_stall) |-> rsp_valid_ff)
      else $error("stalled response dropped");
`endif

endmodule
